// ===== hdl/tcp_port_byte_counter_assert.svh =====
// Assertion macros used by the checker file of the port byte counter.
// CHK_RESET: property sampled on every edge, reset included.
// CHK_RUN: property sampled only while reset is low.
`ifndef TCP_PORT_BYTE_COUNTER_ASSERT_SVH
`define TCP_PORT_BYTE_COUNTER_ASSERT_SVH

`define CHK_RESET(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`define CHK_RUN(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

`endif

// ===== hdl/tpbc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpbc_pkg
// Types, constants and codes shared by the TCP port byte counter modules.
// ----------------------------------------------------------------------------
package tpbc_pkg;

  localparam int unsigned PORT_ENTRIES = 1024;
  localparam int unsigned SLOT_W = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  localparam logic CMD_ACCOUNT = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  localparam logic [1:0] CFG_HOST_ADDR = 2'd0;
  localparam logic [1:0] CFG_PORT_LOW  = 2'd1;
  localparam logic [1:0] CFG_PORT_HIGH = 2'd2;

  localparam logic [31:0] HOST_ADDR_RESET = 32'd0;
  localparam logic [15:0] PORT_LOW_RESET  = 16'd1;
  localparam logic [15:0] PORT_HIGH_RESET = 16'd1024;

  typedef struct packed {
    logic        command;
    logic [15:0] eth_type;
    logic [7:0]  ip_protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] frame_length;
    logic [15:0] read_port;
  } item_t;

  typedef struct packed {
    logic [31:0] out_bytes;
    logic [31:0] in_bytes;
    logic        in_window;
  } result_t;

  // Classified request handed from the front end to the counter engine.
  typedef struct packed {
    logic              is_read;
    logic              out_en;
    logic [SLOT_W-1:0] out_slot;
    logic              in_en;
    logic [SLOT_W-1:0] in_slot;
    logic [15:0]       length;
    logic              in_window;
  } op_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } back_state_t;

endpackage

// ===== hdl/tpbc_ram.sv =====
// ----------------------------------------------------------------------------
// tpbc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpbc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tpbc_front.sv =====
// ----------------------------------------------------------------------------
// tpbc_front
// Holds the configuration registers and classifies incoming requests.
// ----------------------------------------------------------------------------
module tpbc_front import tpbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  item_t       item,
  output op_t         op,
  output logic        keep
);

  logic [31:0] host_addr;
  logic [15:0] port_low;
  logic [15:0] port_high;

  logic              src_ok, dst_ok, rd_ok;
  logic [SLOT_W-1:0] src_slot, dst_slot, rd_slot;
  logic              is_tcp;

  function automatic logic counted(input logic [15:0] port, input logic [15:0] lo,
                                   input logic [15:0] hi);
    logic [15:0] off;
    off = port - lo;
    return (port >= lo) && (port <= hi) && ({1'b0, off} < 17'(PORT_ENTRIES));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      host_addr <= HOST_ADDR_RESET;
      port_low  <= PORT_LOW_RESET;
      port_high <= PORT_HIGH_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_HOST_ADDR: host_addr <= cfg_data;
        CFG_PORT_LOW:  port_low  <= cfg_data[15:0];
        CFG_PORT_HIGH: port_high <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    src_ok   = counted(item.src_port, port_low, port_high);
    dst_ok   = counted(item.dst_port, port_low, port_high);
    rd_ok    = counted(item.read_port, port_low, port_high);
    src_slot = SLOT_W'(item.src_port - port_low);
    dst_slot = SLOT_W'(item.dst_port - port_low);
    rd_slot  = SLOT_W'(item.read_port - port_low);
    is_tcp   = (item.eth_type == ETHERTYPE_IPV4) && (item.ip_protocol == PROTO_TCP);

    op.is_read   = (item.command == CMD_READ);
    op.length    = item.frame_length;
    op.in_window = rd_ok;
    if (item.command == CMD_READ) begin
      op.out_en   = 1'b0;
      op.in_en    = 1'b0;
      op.out_slot = rd_slot;
      op.in_slot  = rd_slot;
    end else begin
      op.out_en   = is_tcp && (item.src_addr == host_addr) && src_ok;
      op.in_en    = is_tcp && (item.dst_addr == host_addr) && dst_ok;
      op.out_slot = src_slot;
      op.in_slot  = dst_slot;
    end
    // drop packets that touch no counter
    keep = op.is_read || op.out_en || op.in_en;
  end

endmodule

// ===== hdl/tpbc_queue.sv =====
// ----------------------------------------------------------------------------
// tpbc_queue
// Short register queue between the front end and the counter engine.
// ----------------------------------------------------------------------------
module tpbc_queue import tpbc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  op_t  wr_op,
  output logic full,
  input  logic rd_en,
  output op_t  rd_op,
  output logic empty
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rd_op = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/tpbc_back.sv =====
// ----------------------------------------------------------------------------
// tpbc_back
// Counter engine: clears the counter memories, then runs each request as a
// memory read followed by an update or a result.
// ----------------------------------------------------------------------------
module tpbc_back import tpbc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_empty,
  input  op_t          q_op,
  output logic         q_pop,
  output result_t      result,
  output logic         empty,
  input  logic         pop,
  output back_status_t status
);

  back_state_t state, state_next;
  op_t         op;
  logic [SLOT_W-1:0] clear_idx;
  logic        clear_last;

  logic              out_we, in_we;
  logic [SLOT_W-1:0] out_waddr, in_waddr, out_raddr, in_raddr;
  logic [31:0]       out_wdata, in_wdata, out_rdata, in_rdata;
  logic              res_valid;
  logic              res_load;

  tpbc_ram #(.WIDTH(32), .DEPTH(PORT_ENTRIES)) u_out_ram (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_waddr),
    .wdata (out_wdata),
    .raddr (out_raddr),
    .rdata (out_rdata)
  );

  tpbc_ram #(.WIDTH(32), .DEPTH(PORT_ENTRIES)) u_in_ram (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_waddr),
    .wdata (in_wdata),
    .raddr (in_raddr),
    .rdata (in_rdata)
  );

  assign clear_last      = (clear_idx == SLOT_W'(PORT_ENTRIES - 1));
  assign empty           = !res_valid;
  assign status.clearing = (state == ST_CLEAR);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clear_last) state_next = ST_IDLE;
      ST_IDLE:  if (!q_empty) state_next = ST_EXEC;
      ST_EXEC: begin
        if (!op.is_read || !res_valid || pop) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    res_load  = 1'b0;
    out_we    = 1'b0;
    in_we     = 1'b0;
    out_waddr = op.out_slot;
    in_waddr  = op.in_slot;
    out_wdata = out_rdata + {16'd0, op.length};
    in_wdata  = in_rdata + {16'd0, op.length};
    out_raddr = op.out_slot;
    in_raddr  = op.in_slot;
    case (state)
      ST_CLEAR: begin
        out_we    = 1'b1;
        in_we     = 1'b1;
        out_waddr = clear_idx;
        in_waddr  = clear_idx;
        out_wdata = '0;
        in_wdata  = '0;
      end
      ST_IDLE: begin
        q_pop     = !q_empty;
        out_raddr = q_op.out_slot;
        in_raddr  = q_op.in_slot;
      end
      ST_EXEC: begin
        out_we   = op.out_en;
        in_we    = op.in_en;
        res_load = op.is_read && (!res_valid || pop);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_idx <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clear_idx <= clear_idx + 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op <= q_op;
    end
    if (res_load) begin
      result.out_bytes <= op.in_window ? out_rdata : 32'd0;
      result.in_bytes  <= op.in_window ? in_rdata : 32'd0;
      result.in_window <= op.in_window;
    end
  end

endmodule

// ===== hdl/tcp_port_byte_counter.sv =====
// ----------------------------------------------------------------------------
// tcp_port_byte_counter
// Per-TCP-port outgoing and incoming byte counters for one monitored host.
// ----------------------------------------------------------------------------
// Push parsed packet headers or counter reads in; pop read results out. The
// front end classifies each request in the cycle it is taken and drops packets
// that hit no counter; counted packets and reads wait in a four-entry queue.
// The counter engine owns two counter memories, each with one write and one
// read port, and runs one queued request at a time (registered memory read,
// then add-and-write or result load); a read waits until its result can be
// loaded. Uncounted packets cost nothing beyond the push. After reset the
// engine zeroes all PORT_ENTRIES counters, one entry per cycle, and holds full
// high while it clears; configuration writes are taken as usual.
// Configure host_addr, port_low and port_high only while no request is in
// flight. Counters are 32 bits and wrap.
// ----------------------------------------------------------------------------
module tcp_port_byte_counter import tpbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // requests
  input  logic        push,
  input  item_t       item,
  output logic        full,
  // results
  output logic        empty,
  input  logic        pop,
  output result_t     result
);

  op_t          front_op;
  logic         front_keep;
  op_t          q_op;
  logic         q_full, q_empty, q_pop;
  back_status_t back_status;
  logic         accept;

  // hold requests off while the queue is full or memories are clearing
  assign full   = q_full || back_status.clearing;
  assign accept = push && !full;

  tpbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .op        (front_op),
    .keep      (front_keep)
  );

  // enqueue only requests that read or update a counter
  tpbc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr_en (accept && front_keep),
    .wr_op (front_op),
    .full  (q_full),
    .rd_en (q_pop),
    .rd_op (q_op),
    .empty (q_empty)
  );

  tpbc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_op    (q_op),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop),
    .status  (back_status)
  );

endmodule

// ===== hdl/tpbc_checker.sv =====
// ----------------------------------------------------------------------------
// tpbc_checker
// Port-level checks on the TCP port byte counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "tcp_port_byte_counter_assert.svh"

module tpbc_checker import tpbc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  logic out_of_window;
  logic zero_counts;

  assign out_of_window = !empty && !result.in_window;
  assign zero_counts   = (result.out_bytes == 32'd0) && (result.in_bytes == 32'd0);

  // reset flushes results and starts the clearing pass
  `CHK_RESET(a_rst_empty, clk, rst |=> empty, "result pending after reset")
  `CHK_RESET(a_rst_full, clk, rst |=> full, "requests taken during clearing pass")
  // reads outside the window answer with zero counts
  `CHK_RUN(a_window_zero, clk, rst, out_of_window |-> zero_counts, "nonzero count outside window")
  // an unpopped result stays put
  `CHK_RUN(a_hold, clk, rst, (!empty && !pop) |=> (!empty && $stable(result)), "result dropped")

endmodule

bind tcp_port_byte_counter tpbc_checker u_tpbc_checker (.*);
